// ===== rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// shared types and codes for the indexed list store: request and result
// payloads, operation and status codes, and the per-cell control word
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

   localparam int CAPACITY_DEF = 16;

   typedef logic [2:0] kind_type;
   localparam kind_type KIND_APPEND = 3'd0;
   localparam kind_type KIND_INSERT = 3'd1;
   localparam kind_type KIND_ERASE  = 3'd2;
   localparam kind_type KIND_POP    = 3'd3;
   localparam kind_type KIND_READ   = 3'd4;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] value;
      logic [3:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [4:0]         count;
      status_type         status;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ERASE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// one list slot: holds a word and takes it from its left or right neighbour,
// or the new word, according to the broadcast operation and target slot
// ----------------------------------------------------------------------------
`default_nettype none

module ils_cell #(
   parameter int IDX_W = 4,
   parameter int IDX   = 0
) (
   input  wire logic                   clock,
   input  wire ils_pkg::cell_ctrl_type ctrl,
   input  wire logic [IDX_W-1:0]       tgt,
   input  wire logic signed [31:0]     left_data,
   input  wire logic signed [31:0]     right_data,
   output logic signed [31:0]          data
);
   import ils_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (MY_IDX > tgt) begin
               data_in = left_data;
            end else if (MY_IDX == tgt) begin
               data_in = ctrl.value;
            end
         end
         CELL_ERASE: begin
            // later entries move down one slot
            if (MY_IDX >= tgt) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_store_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_top
// ordered list of signed 32-bit words with append, insert, erase, pop and
// read, built as a row of register cells that shift in parallel
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while req_stall is low and its result
// appears in the output register on the following cycle, so an insert or
// erase that moves many entries takes as long as any other request: every cell
// of the row loads from its neighbour at the same edge. A new request is
// taken whenever the output register is empty or its result is being taken in
// that cycle. The list holds up to CAPACITY words; only positions 0 to 15 can
// be addressed by a request and the reported count is the low five bits of the
// entry count. Entries that were never written hold no defined value, but no
// request can read one.
`default_nettype none

module indexed_list_store_top #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ils_pkg::req_type req_data,
   // result channel
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ils_pkg::rsp_type      rsp_data
);
   import ils_pkg::*;

   // count runs 0..CAPACITY, a slot index 0..CAPACITY-1
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   // entry count and result register
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;

   logic req_accept;

   // cell row control
   cell_ctrl_type      cell_ctrl;
   logic [IW-1:0]      cell_tgt;
   logic signed [31:0] cell_data [CAPACITY];

   // decode
   logic [CW+3:0]      cnt_w;
   logic [CW+3:0]      pos_w;
   logic [CW-1:0]      cnt_dec;
   logic               full;
   logic               empty;
   logic               rd_en;
   logic [IW-1:0]      rd_idx;
   logic signed [31:0] rd_word;
   status_type         status;
   logic [CW+4:0]      count_ext;

   // request is taken while the output register is free or draining
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign cnt_w   = {4'b0, count_ff};
   assign pos_w   = {{CW{1'b0}}, req_data.position};
   assign cnt_dec = count_ff - ONE_C;
   assign full    = (count_ff == CAP_C);
   assign empty   = (count_ff == '0);

   // operation decode, each special case leaves the list untouched
   always_comb begin
      cell_ctrl.op    = CELL_HOLD;
      cell_ctrl.value = req_data.value;
      cell_tgt        = pos_w[IW-1:0];
      count_in        = count_ff;
      rd_en           = 1'b0;
      rd_idx          = pos_w[IW-1:0];
      status          = ST_OK;
      case (req_data.kind)
         KIND_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               // append is an insert at the end
               cell_ctrl.op = CELL_INSERT;
               cell_tgt     = count_ff[IW-1:0];
               count_in     = count_ff + ONE_C;
            end
         end
         KIND_INSERT: begin
            // full check takes priority over the position check
            if (full) begin
               status = ST_FULL;
            end else if (pos_w > cnt_w) begin
               status = ST_RANGE;
            end else begin
               cell_ctrl.op = CELL_INSERT;
               count_in     = count_ff + ONE_C;
            end
         end
         KIND_ERASE: begin
            if (pos_w >= cnt_w) begin
               status = ST_RANGE;
            end else begin
               cell_ctrl.op = CELL_ERASE;
               count_in     = cnt_dec;
            end
         end
         KIND_POP: begin
            if (empty) begin
               status = ST_RANGE;
            end else begin
               rd_en    = 1'b1;
               rd_idx   = cnt_dec[IW-1:0];
               count_in = cnt_dec;
            end
         end
         KIND_READ: begin
            if (pos_w >= cnt_w) begin
               status = ST_RANGE;
            end else begin
               rd_en = 1'b1;
            end
         end
         default: begin
            // unknown kinds
            status = ST_RANGE;
         end
      endcase
      if (!req_accept) begin
         cell_ctrl.op = CELL_HOLD;
         count_in     = count_ff;
      end
   end

   // row of cells, each one shifting against its neighbours
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_w;
      logic signed [31:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = req_data.value;
      end else begin : g_left
         assign left_w = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = cell_data[i];
      end else begin : g_right
         assign right_w = cell_data[i+1];
      end
      ils_cell #(
         .IDX_W (IW),
         .IDX   (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .tgt        (cell_tgt),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[i])
      );
   end

   // single read port into the row for pop and read
   assign rd_word = cell_data[rd_idx];

   assign count_ext = {5'b0, count_in};

   always_comb begin
      rsp_data_in.data   = rd_en ? rd_word : 32'sd0;
      rsp_data_in.count  = count_ext[4:0];
      rsp_data_in.status = status;
      rsp_valid_in       = req_accept | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload only loads with a new request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
